// ===== rtl/core/xxh_pkg.sv =====
package xxh_pkg;

   localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
   localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
   localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
   localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
   localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

   // one queued beat between front and back
   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  cnt;   // clamped to 0..8, 8 for non-last beats
      logic        last;
   } beat_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LANE, ST_CONV, ST_MERGE, ST_TAILW, ST_LASTW,
      ST_TAIL4, ST_TAIL1, ST_AVAL, ST_OUT
   } state_type;

   function automatic logic [63:0] rotl(input logic [63:0] v, input logic [5:0] n);
      logic [127:0] d;
      d = {v, v} << n;
      return d[127:64];
   endfunction

endpackage

// ===== rtl/core/xxh_front.sv =====
// Classify beats and queue them for the back end.
module xxh_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               flush,
   input  logic               req_push,
   output logic               req_full,
   input  logic [63:0]        req_data_word,
   input  logic [3:0]         req_byte_count,
   input  logic               req_last_word,
   output logic               q_valid,
   output xxh_pkg::beat_type  q_beat,
   input  logic               q_take
);
   xxh_pkg::beat_type q_mem_ff [2];
   logic              wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   xxh_pkg::beat_type beat;
   logic              do_push, do_pop;

   // clamp count; non-last beats always carry eight bytes
   always_comb begin
      beat.word = req_data_word;
      beat.last = req_last_word;
      if (!req_last_word || req_byte_count > 4'd8) beat.cnt = 4'd8;
      else beat.cnt = req_byte_count;
   end

   assign req_full = (count_ff == 2'd2) || flush;
   assign do_push  = req_push && !req_full;
   assign q_valid  = (count_ff != 2'd0);
   assign do_pop   = q_take && q_valid;
   assign q_beat   = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the beat
   always_ff @(posedge clock) begin
      if (do_push) q_mem_ff[wr_ptr_ff] <= beat;
   end
endmodule

// ===== rtl/core/xxh_back.sv =====
// Run lane rounds and the digest sequence on a two-stage 64-bit multiplier.
// A multiply loaded at one step is read back after its operand and partial-product registers.
module xxh_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [63:0]        csr_seed_value,
   input  logic               q_valid,
   input  xxh_pkg::beat_type  q_beat,
   output logic               q_take,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [63:0]        rsp_hash_value
);
   xxh_pkg::state_type state_ff, state_in;
   logic [63:0] seed_ff;
   logic [63:0] lane_ff [4];
   logic [63:0] stripe_ff [4];
   logic [1:0]  fill_ff, fill_in;
   logic [63:0] len_ff, len_in;
   logic [63:0] h_ff, h_in;
   xxh_pkg::beat_type cur_ff, cur_in;
   logic [1:0]  idx_ff, idx_in;   // lane / tail word index
   logic [2:0]  step_ff, step_in; // sub-step within an operation
   logic [2:0]  bidx_ff, bidx_in; // byte index for the 1-byte pieces
   logic [63:0] out_ff;
   logic        out_valid_ff, out_valid_in;
   logic        restart;
   // multiplier: registered operands, registered 32x32 partial products
   logic [63:0] ma_ff, mb_ff, ma_in, mb_in;
   logic [63:0] pll_ff;
   logic [31:0] plh_ff, phl_ff;
   logic [63:0] mp;
   logic [63:0] lane_wr;
   logic        lane_we;
   logic [63:0] s_wr;
   logic        s_we;
   logic [63:0] byte_v;

   assign rsp_empty      = !out_valid_ff;
   assign rsp_hash_value = out_ff;
   assign byte_v         = {56'd0, cur_ff.word[{bidx_ff, 3'b000} +: 8]};
   // combine partial products into the low 64 bits of the product
   assign mp             = pll_ff + {plh_ff + phl_ff, 32'd0};

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      h_in         = h_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      bidx_in      = bidx_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      q_take       = 1'b0;
      lane_we      = 1'b0;
      lane_wr      = mp;
      s_we         = 1'b0;
      s_wr         = cur_ff.word;
      restart      = 1'b0;
      unique case (state_ff)
         xxh_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_take  = 1'b1;
               cur_in  = q_beat;
               len_in  = len_ff + {60'd0, q_beat.cnt};
               step_in = 3'd0;
               idx_in  = 2'd0;
               if (!q_beat.last || (fill_ff == 2'd3 && q_beat.cnt == 4'd8)) begin
                  state_in = (fill_ff == 2'd3) ? xxh_pkg::ST_LANE : xxh_pkg::ST_IDLE;
                  s_we     = 1'b1;
                  s_wr     = q_beat.word;
                  if (fill_ff != 2'd3) fill_in = fill_ff + 2'd1;
               end else begin
                  state_in = xxh_pkg::ST_CONV;
               end
            end
         end
         // four lane rounds: acc += w*P2; acc = rotl(acc,31)*P1
         xxh_pkg::ST_LANE: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: begin ma_in = stripe_ff[idx_ff]; mb_in = xxh_pkg::PRIME2; end
               3'd2: begin
                  ma_in = xxh_pkg::rotl(lane_ff[idx_ff] + mp, 6'd31);
                  mb_in = xxh_pkg::PRIME1;
               end
               3'd4: begin
                  lane_we = 1'b1;
                  step_in = 3'd0;
                  idx_in  = idx_ff + 2'd1;
                  if (idx_ff == 2'd3) begin
                     fill_in  = 2'd0;
                     idx_in   = 2'd0;
                     state_in = cur_ff.last ? xxh_pkg::ST_CONV : xxh_pkg::ST_IDLE;
                     if (cur_ff.last) cur_in.cnt = 4'd0;
                  end
               end
               default: ;
            endcase
         end
         xxh_pkg::ST_CONV: begin
            idx_in  = 2'd0;
            step_in = 3'd0;
            if (len_ff >= 64'd32) begin
               h_in = xxh_pkg::rotl(lane_ff[0], 6'd1) + xxh_pkg::rotl(lane_ff[1], 6'd7)
                    + xxh_pkg::rotl(lane_ff[2], 6'd12) + xxh_pkg::rotl(lane_ff[3], 6'd18);
               state_in = xxh_pkg::ST_MERGE;
            end else begin
               h_in = seed_ff + xxh_pkg::PRIME5 + len_ff;
               state_in = (fill_ff != 2'd0) ? xxh_pkg::ST_TAILW : xxh_pkg::ST_LASTW;
            end
         end
         // merge: h = (h ^ rotl(lane*P2,31)*P1)*P1 + P4
         xxh_pkg::ST_MERGE: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: begin ma_in = lane_ff[idx_ff]; mb_in = xxh_pkg::PRIME2; end
               3'd2: begin ma_in = xxh_pkg::rotl(mp, 6'd31); mb_in = xxh_pkg::PRIME1; end
               3'd4: begin ma_in = h_ff ^ mp; mb_in = xxh_pkg::PRIME1; end
               3'd6: begin
                  step_in = 3'd0;
                  h_in    = mp + xxh_pkg::PRIME4;
                  idx_in  = idx_ff + 2'd1;
                  if (idx_ff == 2'd3) begin
                     idx_in   = 2'd0;
                     h_in     = mp + xxh_pkg::PRIME4 + len_ff;
                     state_in = (fill_ff != 2'd0) ? xxh_pkg::ST_TAILW : xxh_pkg::ST_LASTW;
                  end
               end
               default: ;
            endcase
         end
         // tail word: h = rotl(h ^ round(0,w),27)*P1 + P4
         xxh_pkg::ST_TAILW, xxh_pkg::ST_LASTW: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: begin
                  ma_in = (state_ff == xxh_pkg::ST_TAILW) ? stripe_ff[idx_ff] : cur_ff.word;
                  mb_in = xxh_pkg::PRIME2;
                  if (state_ff == xxh_pkg::ST_LASTW && cur_ff.cnt != 4'd8) begin
                     step_in  = 3'd0;
                     bidx_in  = 3'd0;
                     state_in = (cur_ff.cnt >= 4'd4) ? xxh_pkg::ST_TAIL4
                              : (cur_ff.cnt != 4'd0) ? xxh_pkg::ST_TAIL1 : xxh_pkg::ST_AVAL;
                  end
               end
               3'd2: begin ma_in = xxh_pkg::rotl(mp, 6'd31); mb_in = xxh_pkg::PRIME1; end
               3'd4: begin
                  ma_in = xxh_pkg::rotl(h_ff ^ mp, 6'd27);
                  mb_in = xxh_pkg::PRIME1;
               end
               3'd6: begin
                  step_in = 3'd0;
                  h_in    = mp + xxh_pkg::PRIME4;
                  if (state_ff == xxh_pkg::ST_LASTW) begin
                     state_in = xxh_pkg::ST_AVAL;
                  end else if (idx_ff + 2'd1 == fill_ff) begin
                     idx_in   = 2'd0;
                     state_in = xxh_pkg::ST_LASTW;
                  end else begin
                     idx_in = idx_ff + 2'd1;
                  end
               end
               default: ;
            endcase
         end
         // 4-byte piece: h = rotl(h ^ w32*P1,23)*P2 + P3
         xxh_pkg::ST_TAIL4: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: begin ma_in = {32'd0, cur_ff.word[31:0]}; mb_in = xxh_pkg::PRIME1; end
               3'd2: begin ma_in = xxh_pkg::rotl(h_ff ^ mp, 6'd23); mb_in = xxh_pkg::PRIME2; end
               3'd4: begin
                  h_in     = mp + xxh_pkg::PRIME3;
                  bidx_in  = 3'd4;
                  step_in  = 3'd0;
                  state_in = (cur_ff.cnt > 4'd4) ? xxh_pkg::ST_TAIL1 : xxh_pkg::ST_AVAL;
               end
               default: ;
            endcase
         end
         // 1-byte piece: h = rotl(h ^ b*P5,11)*P1
         xxh_pkg::ST_TAIL1: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: begin ma_in = byte_v; mb_in = xxh_pkg::PRIME5; end
               3'd2: begin ma_in = xxh_pkg::rotl(h_ff ^ mp, 6'd11); mb_in = xxh_pkg::PRIME1; end
               3'd4: begin
                  h_in    = mp;
                  step_in = 3'd0;
                  bidx_in = bidx_ff + 3'd1;
                  if ({1'b0, bidx_ff} + 4'd1 >= cur_ff.cnt) state_in = xxh_pkg::ST_AVAL;
               end
               default: ;
            endcase
         end
         // avalanche: xor-shift 33, *P2, xor-shift 29, *P3, xor-shift 32
         xxh_pkg::ST_AVAL: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: begin ma_in = h_ff ^ (h_ff >> 33); mb_in = xxh_pkg::PRIME2; end
               3'd2: begin ma_in = mp ^ (mp >> 29); mb_in = xxh_pkg::PRIME3; end
               3'd4: begin
                  step_in  = 3'd0;
                  h_in     = mp ^ (mp >> 32);
                  state_in = xxh_pkg::ST_OUT;
               end
               default: ;
            endcase
         end
         // hold the digest until the result register is free
         xxh_pkg::ST_OUT: begin
            if (!out_valid_ff) begin
               out_valid_in = 1'b1;
               restart      = 1'b1;
               state_in     = xxh_pkg::ST_IDLE;
            end
         end
         default: state_in = xxh_pkg::ST_IDLE;
      endcase
      if (restart || csr_write) begin
         fill_in = 2'd0;
         len_in  = 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xxh_pkg::ST_IDLE;
         fill_ff      <= 2'd0;
         len_ff       <= 64'd0;
         idx_ff       <= 2'd0;
         step_ff      <= 3'd0;
         bidx_ff      <= 3'd0;
         out_valid_ff <= 1'b0;
         seed_ff      <= 64'd0;
         lane_ff[0]   <= xxh_pkg::PRIME1 + xxh_pkg::PRIME2;
         lane_ff[1]   <= xxh_pkg::PRIME2;
         lane_ff[2]   <= 64'd0;
         lane_ff[3]   <= 64'd0 - xxh_pkg::PRIME1;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         bidx_ff      <= bidx_in;
         out_valid_ff <= out_valid_in;
         if (csr_write) begin
            seed_ff    <= csr_seed_value;
            lane_ff[0] <= csr_seed_value + xxh_pkg::PRIME1 + xxh_pkg::PRIME2;
            lane_ff[1] <= csr_seed_value + xxh_pkg::PRIME2;
            lane_ff[2] <= csr_seed_value;
            lane_ff[3] <= csr_seed_value - xxh_pkg::PRIME1;
         end else if (restart) begin
            lane_ff[0] <= seed_ff + xxh_pkg::PRIME1 + xxh_pkg::PRIME2;
            lane_ff[1] <= seed_ff + xxh_pkg::PRIME2;
            lane_ff[2] <= seed_ff;
            lane_ff[3] <= seed_ff - xxh_pkg::PRIME1;
         end else if (lane_we) begin
            lane_ff[idx_ff] <= lane_wr;
         end
      end
   end

   // payload registers and the multiplier stages
   always_ff @(posedge clock) begin
      h_ff   <= h_in;
      cur_ff <= cur_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      pll_ff <= {32'd0, ma_ff[31:0]} * {32'd0, mb_ff[31:0]};
      plh_ff <= ma_ff[31:0] * mb_ff[63:32];
      phl_ff <= ma_ff[63:32] * mb_ff[31:0];
      if (restart) out_ff <= h_ff;
      if (s_we) stripe_ff[fill_ff] <= s_wr;
   end
endmodule

// ===== rtl/core/xxhash64_stream.sv =====
// channel | direction | handshake        | payload
// req     | in        | req_push/req_full | data_word, byte_count, last_word
// rsp     | out       | rsp_pop/rsp_empty | hash_value
// csr     | in        | csr_write         | seed_value
// A non-last beat is stored as a stripe word in the back end; one that completes a stripe
// also runs four lane rounds on one shared two-stage multiplier.
// A last beat runs the merge, tail-piece and avalanche steps on that multiplier.
// A two-deep queue feeds the back end.
// Reset is synchronous; a digest waits in rsp until popped, and the next digest
// holds at its final step meanwhile.
module xxhash64_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_last_word,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_hash_value,
   input  logic        csr_write,
   input  logic [63:0] csr_seed_value
);
   logic              q_valid, q_take;
   xxh_pkg::beat_type q_beat;

   xxh_front u_front (
      .clock, .reset, .flush(1'b0), .req_push, .req_full, .req_data_word,
      .req_byte_count, .req_last_word, .q_valid, .q_beat, .q_take
   );

   xxh_back u_back (
      .clock, .reset, .csr_write, .csr_seed_value, .q_valid, .q_beat, .q_take,
      .rsp_empty, .rsp_pop, .rsp_hash_value
   );
endmodule

// ===== rtl/core/xxh_check.sv =====
module xxh_check (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [63:0] rsp_hash_value
);
   // hold a waiting digest until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_hash_value)))
      else $error("digest dropped while waiting");
   // a popped digest is never shown again next cycle
   a_pop: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop) |=> rsp_empty)
      else $error("digest repeated");
   // nothing leaves right after reset
   a_rst: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("digest after reset");
endmodule

bind xxhash64_stream xxh_check u_check (
   .clock, .reset, .rsp_empty, .rsp_pop, .rsp_hash_value
);

// ===== sim/tb_xxhash64_stream.sv =====
// Seeded XXH64 digest checks: a class predicts each message digest and
// compares popped digests in order against the queue of expected values.
class digest_board;
   logic [63:0] seed;
   logic [63:0] lanes[4];
   logic [63:0] stripe[4];
   int unsigned fill;
   logic [63:0] total_len;
   logic [63:0] digests_due[$];
   int unsigned errors;

   function new();
      seed = '0;
      errors = 0;
      stripe[0] = '0; stripe[1] = '0; stripe[2] = '0; stripe[3] = '0;
      reload();
   endfunction

   static function logic [63:0] rol(logic [63:0] v, int unsigned n);
      if (n == 0) return v;
      return (v << n) | (v >> (64 - n));
   endfunction

   static function logic [63:0] round64(logic [63:0] acc, logic [63:0] w);
      logic [63:0] a;
      a = acc + w * xxh_pkg::PRIME2;
      return rol(a, 31) * xxh_pkg::PRIME1;
   endfunction

   static function logic [63:0] fold8(logic [63:0] h, logic [63:0] w);
      return rol(h ^ round64(64'd0, w), 27) * xxh_pkg::PRIME1 + xxh_pkg::PRIME4;
   endfunction

   function void reload();
      lanes[0] = seed + xxh_pkg::PRIME1 + xxh_pkg::PRIME2;
      lanes[1] = seed + xxh_pkg::PRIME2;
      lanes[2] = seed;
      lanes[3] = seed - xxh_pkg::PRIME1;
      fill = 0;
      total_len = '0;
   endfunction

   function void set_seed(logic [63:0] s);
      seed = s;
      reload();
   endfunction

   function void mix_stripe();
      for (int k = 0; k < 4; k++) lanes[k] = round64(lanes[k], stripe[k]);
      fill = 0;
   endfunction

   // note one accepted input beat
   function void note_beat(logic [63:0] w, logic [3:0] bc, logic lst);
      int unsigned cnt;
      logic [63:0] h;
      logic [63:0] b;
      int unsigned k;
      if (!lst) begin
         stripe[fill] = w;
         fill++;
         total_len += 8;
         if (fill == 4) mix_stripe();
         return;
      end
      cnt = (bc > 8) ? 8 : bc;
      total_len += cnt;
      if (fill == 3 && cnt == 8) begin
         stripe[3] = w;
         mix_stripe();
         cnt = 0;
      end
      if (total_len >= 32) begin
         h = rol(lanes[0], 1) + rol(lanes[1], 7) + rol(lanes[2], 12) + rol(lanes[3], 18);
         for (k = 0; k < 4; k++)
            h = (h ^ round64(64'd0, lanes[k])) * xxh_pkg::PRIME1 + xxh_pkg::PRIME4;
      end else begin
         h = seed + xxh_pkg::PRIME5;
      end
      h += total_len;
      for (k = 0; k < fill; k++) h = fold8(h, stripe[k]);
      if (cnt == 8) begin
         h = fold8(h, w);
      end else begin
         k = 0;
         if (cnt >= 4) begin
            h = rol(h ^ ({32'd0, w[31:0]} * xxh_pkg::PRIME1), 23) * xxh_pkg::PRIME2
                + xxh_pkg::PRIME3;
            k = 4;
         end
         for (; k < cnt; k++) begin
            b = (w >> (8 * k)) & 64'hFF;
            h = rol(h ^ (b * xxh_pkg::PRIME5), 11) * xxh_pkg::PRIME1;
         end
      end
      h ^= h >> 33;
      h *= xxh_pkg::PRIME2;
      h ^= h >> 29;
      h *= xxh_pkg::PRIME3;
      h ^= h >> 32;
      digests_due.push_back(h);
      reload();
   endfunction

   // print one mismatch line and count it
   task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
   endtask

   // check one popped digest against the oldest prediction
   task check_digest(logic [63:0] got);
      logic [63:0] want;
      if (digests_due.size() == 0) begin
         report($sformatf("unexpected digest %h", got));
         return;
      end
      want = digests_due.pop_front();
      if (got !== want)
         report($sformatf("hash_value got %h want %h", got, want));
   endtask
endclass

module tb_xxhash64_stream;
   localparam int unsigned STALL_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [63:0] req_data_word = '0;
   logic [3:0]  req_byte_count = '0;
   logic        req_last_word = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [63:0] rsp_hash_value;
   logic        csr_write = 1'b0;
   logic [63:0] csr_seed_value = '0;

   digest_board board = new();
   bit          calm = 1'b0;
   bit          rsp_idle_on = 1'b1;
   int unsigned quiet_cycles = 0;

   xxhash64_stream u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_data_word(req_data_word), .req_byte_count(req_byte_count),
      .req_last_word(req_last_word),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_hash_value(rsp_hash_value),
      .csr_write(csr_write), .csr_seed_value(csr_seed_value)
   );

   always #10 clock = ~clock;

   // send one beat, with an occasional random idle burst ahead of it
   task automatic send_beat(logic [63:0] w, logic [3:0] bc, logic lst);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_push       <= 1'b1;
      req_data_word  <= w;
      req_byte_count <= bc;
      req_last_word  <= lst;
      do @(posedge clock); while (req_full);
      board.note_beat(w, bc, lst);
   endtask

   task automatic hold_req();
      req_push <= 1'b0;
   endtask

   // send a whole message of nbytes bytes
   task automatic send_message(int unsigned nbytes);
      int unsigned nfull;
      logic [3:0] bc;
      nfull = nbytes / 8;
      if (nbytes % 8 == 0 && nbytes != 0) nfull--;
      for (int unsigned i = 0; i < nfull; i++)
         send_beat({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b0);
      bc = 4'(nbytes - 8 * nfull);
      send_beat({$urandom, $urandom}, bc, 1'b1);
   endtask

   task automatic drain_and_seed(logic [63:0] s);
      hold_req();
      while (board.digests_due.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      csr_write      <= 1'b1;
      csr_seed_value <= s;
      @(posedge clock);
      csr_write <= 1'b0;
      board.set_seed(s);
   endtask

   // result side: pop with random stall bursts
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) board.check_digest(rsp_hash_value);
         if (!calm && rsp_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_pop     <= 1'b0;
            rsp_idle_on <= 1'b0;
            fork begin
               repeat ($urandom_range(1, 18)) @(posedge clock);
               rsp_idle_on <= 1'b1;
            end join_none
         end else begin
            rsp_pop <= rsp_idle_on || calm;
         end
      end
   end

   // watchdog on cycles without any accepted beat or popped digest
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int unsigned beats;
      int unsigned n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: short and stripe-edge messages, odd counts, extremes
      send_message(0);
      send_message(1);
      send_message(4);
      send_message(7);
      send_message(8);
      send_message(31);
      send_message(32);
      send_message(33);
      send_message(40);
      send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0);
      send_beat(64'h0, 4'd3, 1'b0);
      send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 1'b1);
      send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
      send_beat(64'h0, 4'd0, 1'b1);
      drain_and_seed(64'hFFFF_FFFF_FFFF_FFFF);
      send_message(5);
      send_message(64);
      // a seed write in mid-message restarts it
      send_beat({$urandom, $urandom}, 4'd8, 1'b0);
      drain_and_seed(64'h0);
      send_message(12);

      // random messages, mostly small, some seed changes
      beats = 0;
      while (beats < 800) begin
         if ($urandom_range(0, 40) == 0)
            drain_and_seed($urandom_range(0, 3) == 0 ? 64'h0 : {$urandom, $urandom});
         if ($urandom_range(0, 15) == 0) n = $urandom_range(0, 200);
         else n = $urandom_range(0, 48);
         if (beats > 650) calm = 1'b1;
         send_message(n);
         beats += n / 8 + 1;
      end
      hold_req();

      while (board.digests_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
